// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define LSGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define LSGS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/lsgs_pkg.sv =====
// Types and constants of the least served generator selector.
package lsgs_pkg;

  localparam int unsigned ELAPSED_W  = 40;
  localparam int unsigned MADE_W     = 20;
  localparam int unsigned USE_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned MSUM_W     = 32;
  localparam int unsigned DIS_W      = 8;
  localparam int unsigned EPOCH_W    = 48;
  localparam int unsigned SRC_W      = 3;
  localparam int unsigned MIN_W      = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned US_W       = 26;
  localparam int unsigned THR_W      = MIN_W + 1 + US_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [US_W-1:0] US_PER_MINUTE = US_W'(60000000);

  localparam logic [1:0]       RST_METRIC  = 2'd0;
  localparam logic [MIN_W-1:0] RST_MINUTES = MIN_W'(30);
  localparam logic [CNT_W-1:0] RST_COUNT   = CNT_W'(1);
  localparam logic [DIS_W-1:0] RST_PENALTY = DIS_W'(10);

  typedef enum logic [1:0] {
    METRIC_TIME = 2'd0,
    METRIC_USES = 2'd1,
    METRIC_MADE = 2'd2
  } metric_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRIC  = 2'd0,
    CFG_EPOCH   = 2'd1,
    CFG_COUNT   = 2'd2,
    CFG_PENALTY = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic                 first_round;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic [MADE_W-1:0]    items_made;
  } in_t;

  typedef struct packed {
    logic [SRC_W-1:0] next_source;
    logic             epoch_cleared;
  } out_t;

  typedef struct packed {
    logic [1:0]       metric_mode;
    logic [MIN_W-1:0] epoch_minutes;
    logic [CNT_W-1:0] source_count;
    logic [DIS_W-1:0] penalty_rounds;
    logic [THR_W-1:0] epoch_thr;
  } cfg_t;

  typedef struct packed {
    logic [USE_W-1:0]  use_count;
    logic [TIME_W-1:0] time_sum;
    logic [MSUM_W-1:0] made_sum;
    logic [DIS_W-1:0]  disable_left;
  } entry_t;

endpackage

// ===== hdl/lsgs_ram.sv =====
// Generic single-port-write, registered-read RAM.
module lsgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lsgs_cfg.sv =====
// Configuration registers and registered epoch threshold.
module lsgs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lsgs_pkg::cfg_t                  cfg_o
);
  import lsgs_pkg::*;

  localparam logic [THR_W-1:0] RST_THR =
    THR_W'({1'b0, RST_MINUTES} + 17'd1) * THR_W'(US_PER_MINUTE);

  logic [1:0]       metric_q;
  logic [MIN_W-1:0] minutes_q;
  logic [CNT_W-1:0] count_q;
  logic [DIS_W-1:0] penalty_q;
  logic [THR_W-1:0] thr_q, thr_d;

  assign thr_d = THR_W'({1'b0, minutes_q} + 17'd1) * THR_W'(US_PER_MINUTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q  <= RST_METRIC;
      minutes_q <= RST_MINUTES;
      count_q   <= RST_COUNT;
      penalty_q <= RST_PENALTY;
      thr_q     <= RST_THR;
    end else begin
      thr_q <= thr_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_METRIC:  metric_q  <= cfg_wdata_i[1:0];
          CFG_EPOCH:   minutes_q <= cfg_wdata_i[MIN_W-1:0];
          CFG_COUNT:   count_q   <= cfg_wdata_i[CNT_W-1:0];
          CFG_PENALTY: penalty_q <= cfg_wdata_i[DIS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = '{
    metric_mode:    metric_q,
    epoch_minutes:  minutes_q,
    source_count:   count_q,
    penalty_rounds: penalty_q,
    epoch_thr:      thr_q
  };

endmodule

// ===== hdl/least_served_generator_selector.sv =====
// Top level of the least served generator selector.
//
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, in_data_i | request in
//  out     | out_valid_o, out_stall_i, out_data_o | request out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i   | register write
//
// A result passes the states RD, CHK, SCAN and DONE after its request is taken: a read-modify-write
// of the current source entry (not written for a first-round request), one epoch check, a scan of
// the entry RAM one entry a cycle, then the output load. The next request is taken back in IDLE.
// Reset clears all entries at once through per-entry valid bits.
// The result waits in an output register; a new request is taken meanwhile.
// A stalled output holds the finishing request in its last state.
module least_served_generator_selector #(
  parameter int unsigned MAX_SOURCES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lsgs_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lsgs_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lsgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lsgs_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned CMPW = IW + CNT_W;
  localparam int unsigned EW   = $bits(entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SOURCES - 1);

  cfg_t cfg;

  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    pick_q, pick_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic             cleared_q, cleared_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [MAX_SOURCES-1:0] valid_q, valid_d;
  in_t              req_q;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic          accept, out_load, clr;
  logic [IW-1:0] raddr, waddr, rd_idx;
  logic          we;
  entry_t        rdata, ent, wentry;
  logic [EW-1:0] rdata_raw;

  logic [USE_W:0]   use_sum;
  logic [TIME_W:0]  time_sum;
  logic [MSUM_W:0]  made_sum;
  logic [EPOCH_W:0] epoch_sum;
  logic [TIME_W-1:0] metric;
  logic          mode_ok, in_use;

  lsgs_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  lsgs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SOURCES)
  ) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign rd_idx = (state_q == ST_RD) ? cur_q : idx_q;
  assign ent    = valid_q[rd_idx] ? rdata : '0;

  assign use_sum   = {1'b0, ent.use_count} + (USE_W+1)'(1);
  assign time_sum  = {1'b0, ent.time_sum} + (TIME_W+1)'(req_q.elapsed_us);
  assign made_sum  = {1'b0, ent.made_sum} + (MSUM_W+1)'(req_q.items_made);
  assign epoch_sum = {1'b0, epoch_q} + (EPOCH_W+1)'(req_q.elapsed_us);

  assign clr = (cfg.epoch_minutes != '0) && (epoch_q >= EPOCH_W'(cfg.epoch_thr));

  assign mode_ok = (cfg.metric_mode == METRIC_TIME) || (cfg.metric_mode == METRIC_USES) ||
                   (cfg.metric_mode == METRIC_MADE);
  assign in_use  = CMPW'(idx_q) < CMPW'(cfg.source_count);

  always_comb begin
    case (metric_e'(cfg.metric_mode))
      METRIC_TIME: metric = ent.time_sum;
      METRIC_USES: metric = TIME_W'(ent.use_count);
      METRIC_MADE: metric = TIME_W'(ent.made_sum);
      default:     metric = ent.time_sum;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    pick_d      = pick_q;
    best_d      = best_q;
    cleared_d   = cleared_q;
    epoch_d     = epoch_q;
    valid_d     = valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    raddr       = cur_q;
    waddr       = rd_idx;
    we          = 1'b0;
    wentry      = ent;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        wentry.use_count = use_sum[USE_W] ? '1 : use_sum[USE_W-1:0];
        wentry.time_sum  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
        wentry.made_sum  = made_sum[MSUM_W] ? '1 : made_sum[MSUM_W-1:0];
        if (req_q.items_made == '0) begin
          wentry.disable_left = cfg.penalty_rounds;
        end
        if (!req_q.first_round) begin
          we             = 1'b1;
          valid_d[cur_q] = 1'b1;
          epoch_d        = epoch_sum[EPOCH_W] ? '1 : epoch_sum[EPOCH_W-1:0];
        end
        state_d = ST_CHK;
      end
      ST_CHK: begin
        cleared_d = clr;
        if (clr) begin
          valid_d = '0;
          epoch_d = '0;
        end
        raddr   = '0;
        idx_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        raddr = idx_q + IW'(1);
        if (idx_q == '0) begin
          best_d = metric;
          pick_d = '0;
        end else if (mode_ok && in_use && metric < best_q && ent.disable_left == '0) begin
          best_d = metric;
          pick_d = idx_q;
        end
        if (valid_q[idx_q] && ent.disable_left != '0) begin
          we                  = 1'b1;
          wentry.disable_left = ent.disable_left - DIS_W'(1);
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_d       = '{next_source: SRC_W'(pick_q), epoch_cleared: cleared_q};
          out_valid_d = 1'b1;
          cur_d       = pick_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cur_q       <= '0;
      pick_q      <= '0;
      cleared_q   <= 1'b0;
      epoch_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      pick_q      <= pick_d;
      cleared_q   <= cleared_d;
      epoch_q     <= epoch_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    out_q  <= out_d;
    if (accept) begin
      req_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LSGS_ASSERT(a_accept_reads, accept |=> state_q == ST_RD, "accepted request did not start a read")
  `LSGS_ASSERT(a_clear_wipes, (state_q == ST_CHK && clr) |=> (epoch_q == '0 && valid_q == '0),
               "epoch clear left state behind")
  `LSGS_ASSERT(a_pick_in_use,
               (state_q == ST_DONE) |-> (pick_q == '0 || CMPW'(pick_q) < CMPW'(cfg.source_count)),
               "picked a source that is not in use")
  `LSGS_NEVER(a_load_over_full, out_load && out_valid_q && out_stall_i,
              "result overwrote a stalled result")

endmodule

// ===== tb/least_served_generator_selector_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the least served generator selector: directed table, saturation run, random phases.
module least_served_generator_selector_tb;
  import lsgs_pkg::*;

  localparam int unsigned MAX_SRC       = 8;
  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned TAIL_CYCLES   = 4 * (MAX_SRC + 4);
  localparam int unsigned SAT_REQUESTS  = 260;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_REQS    = 95;
  localparam longint unsigned TIMEOUT_NS = 64'd8_000_000;

  localparam logic [1:0]           METRIC_UNKNOWN = 2'd3;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;
  localparam logic [MADE_W-1:0]    MADE_MAX       = '1;
  localparam logic [63:0]          SUM32_MAX      = 64'hFFFF_FFFF;
  localparam logic [63:0]          SUM48_MAX      = 64'hFFFF_FFFF_FFFF;

  localparam logic [1:0] METRIC_ORDER [4] = '{METRIC_TIME, METRIC_USES, METRIC_MADE,
                                              METRIC_UNKNOWN};

  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic                  pinned;
    in_t                   req;
    out_t                  want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [31] = '{
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b1, 40'd0, 20'd0},              '{3'd0, 1'b0}},
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b0, ELAPSED_MAX, MADE_MAX},     '{3'd0, 1'b1}},
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b0, 40'd0, 20'd0},              '{3'd0, 1'b0}},
    '{1'b1, CFG_COUNT,   16'd4,     1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd100, 20'd0},            '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd5, 20'd7},              '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd0, 20'd0},              '0},
    '{1'b1, CFG_PENALTY, 16'd0,     1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd3, 20'd0},              '0},
    '{1'b1, CFG_PENALTY, 16'd255,   1'b0, '0, '0},
    '{1'b1, CFG_METRIC,  16'(METRIC_USES), 1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd1, 20'd1},              '0},
    '{1'b1, CFG_METRIC,  16'(METRIC_MADE), 1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd1, MADE_MAX},           '0},
    '{1'b1, CFG_METRIC,  16'(METRIC_UNKNOWN), 1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b0, 40'd10, 20'd5},             '{3'd0, 1'b0}},
    '{1'b1, CFG_METRIC,  16'(METRIC_TIME), 1'b0, '0, '0},
    '{1'b1, CFG_COUNT,   16'd15,    1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd0, 20'd9},              '0},
    '{1'b1, CFG_COUNT,   16'd0,     1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b0, 40'd50, 20'd0},             '{3'd0, 1'b0}},
    '{1'b1, CFG_EPOCH,   16'd1,     1'b0, '0, '0},
    '{1'b1, CFG_COUNT,   16'd2,     1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b1, '{1'b0, 40'd120000000, 20'd4},      '{3'd0, 1'b1}},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd119999999, 20'd4},      '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, 40'd1, 20'd4},              '0},
    '{1'b1, CFG_EPOCH,   16'd0,     1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, ELAPSED_MAX, MADE_MAX},     '0},
    '{1'b1, CFG_EPOCH,   16'd65535, 1'b0, '0, '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b1, ELAPSED_MAX, 20'd0},        '0},
    '{1'b0, CFG_METRIC,  16'd0,     1'b0, '{1'b0, ELAPSED_MAX, 20'd0},        '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  logic req_pinned;
  out_t req_want;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned fail_count    = 0;
  out_t        expected_picks [$];

  logic [1:0]       cfg_metric  = RST_METRIC;
  logic [MIN_W-1:0] cfg_minutes = RST_MINUTES;
  logic [CNT_W-1:0] cfg_count   = RST_COUNT;
  logic [DIS_W-1:0] cfg_penalty = RST_PENALTY;

  logic [USE_W-1:0]   src_uses [MAX_SRC] = '{default: '0};
  logic [TIME_W-1:0]  src_time [MAX_SRC] = '{default: '0};
  logic [MSUM_W-1:0]  src_made [MAX_SRC] = '{default: '0};
  logic [DIS_W-1:0]   src_hold [MAX_SRC] = '{default: '0};
  logic [EPOCH_W-1:0] epoch_total = '0;
  logic [SRC_W-1:0]   cur_src     = '0;

  least_served_generator_selector #(
    .MAX_SOURCES(MAX_SRC)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] limit);
    return (a + b > limit) ? limit : a + b;
  endfunction

  function automatic logic [63:0] load_of(input int unsigned idx);
    case (cfg_metric)
      METRIC_TIME: return 64'(src_time[idx]);
      METRIC_USES: return 64'(src_uses[idx]);
      default:     return 64'(src_made[idx]);
    endcase
  endfunction

  function automatic out_t pick_next_source(input in_t req);
    logic [63:0] best;
    int unsigned used;
    out_t        res;
    used = (cfg_count == '0) ? 1 : (cfg_count > MAX_SRC) ? MAX_SRC : int'(cfg_count);
    res  = '0;
    if (!req.first_round) begin
      src_uses[cur_src] = USE_W'(sat_add(64'(src_uses[cur_src]), 64'd1, SUM32_MAX));
      src_time[cur_src] = TIME_W'(sat_add(64'(src_time[cur_src]), 64'(req.elapsed_us),
                                          SUM48_MAX));
      src_made[cur_src] = MSUM_W'(sat_add(64'(src_made[cur_src]), 64'(req.items_made),
                                          SUM32_MAX));
      epoch_total = EPOCH_W'(sat_add(64'(epoch_total), 64'(req.elapsed_us), SUM48_MAX));
      if (req.items_made == '0) src_hold[cur_src] = cfg_penalty;
    end
    if (cfg_minutes != '0 && epoch_total / US_PER_MINUTE > cfg_minutes) begin
      epoch_total = '0;
      for (int i = 0; i < MAX_SRC; i++) begin
        src_uses[i] = '0;
        src_time[i] = '0;
        src_made[i] = '0;
        src_hold[i] = '0;
      end
      res.epoch_cleared = 1'b1;
    end
    if (cfg_metric != METRIC_UNKNOWN) begin
      best = load_of(0);
      for (int i = 1; i < used; i++) begin
        if (load_of(i) < best && src_hold[i] == '0) begin
          best = load_of(i);
          res.next_source = SRC_W'(i);
        end
      end
    end
    cur_src = res.next_source;
    for (int i = 0; i < MAX_SRC; i++) begin
      if (src_hold[i] != '0) src_hold[i] = src_hold[i] - 1'b1;
    end
    return res;
  endfunction

  function automatic in_t random_report();
    in_t r;
    r.first_round = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 5))
      0:       r.elapsed_us = ELAPSED_W'($urandom_range(0, 1000));
      1:       r.elapsed_us = ELAPSED_W'($urandom_range(0, 150_000_000));
      2:       r.elapsed_us = ELAPSED_MAX;
      3:       r.elapsed_us = '0;
      default: r.elapsed_us = ELAPSED_W'({$urandom, $urandom});
    endcase
    case ($urandom_range(0, 5))
      0:       r.items_made = '0;
      1:       r.items_made = MADE_W'($urandom_range(1, 10));
      2:       r.items_made = MADE_MAX;
      default: r.items_made = MADE_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // call at a falling edge; returns at a falling edge with nothing assigned in that step
  task automatic send_request(input in_t req, input logic pinned, input out_t want);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    req_pinned <= pinned;
    req_want   <= want;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_picks();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_picks.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_METRIC: cfg_metric  = val[1:0];
      CFG_EPOCH:  cfg_minutes = val;
      CFG_COUNT:  cfg_count   = val[CNT_W-1:0];
      default:    cfg_penalty = val[DIS_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    out_t pred;
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pred = pick_next_source(in_data_i);
        expected_picks.insert(expected_picks.size(), req_pinned ? req_want : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("unexpected request out", out_data_o, 0);
        end else begin
          want = expected_picks.pop_front();
          if (out_data_o.next_source !== want.next_source) begin
            report_mismatch("next_source", out_data_o.next_source, want.next_source);
          end
          if (out_data_o.epoch_cleared !== want.epoch_cleared) begin
            report_mismatch("epoch_cleared", out_data_o.epoch_cleared, want.epoch_cleared);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    req_pinned  = 1'b0;
    req_want    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_METRIC;
    cfg_wdata_i = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg) begin
        drain_picks();
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].wdata);
      end else begin
        send_request(DIRECTED[r].req, DIRECTED[r].pinned, DIRECTED[r].want);
      end
    end

    // saturate the time and epoch sums of source 0
    drain_picks();
    write_reg(CFG_METRIC, 16'(METRIC_MADE));
    write_reg(CFG_EPOCH, 16'd0);
    write_reg(CFG_COUNT, 16'd1);
    for (int n = 0; n < SAT_REQUESTS; n++) begin
      send_request('{1'b0, ELAPSED_MAX, MADE_MAX}, 1'b0, '0);
    end
    drain_picks();
    write_reg(CFG_COUNT, 16'd3);
    for (int n = 0; n < 20; n++) send_request(random_report(), 1'b0, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain_picks();
      write_reg(CFG_METRIC, 16'(METRIC_ORDER[(p + p / 4) % 4]));
      case (p % 5)
        0:       write_reg(CFG_EPOCH, 16'd65535);
        1:       write_reg(CFG_EPOCH, 16'd0);
        2:       write_reg(CFG_EPOCH, 16'd1);
        3:       write_reg(CFG_EPOCH, 16'($urandom_range(2, 100)));
        default: write_reg(CFG_EPOCH, 16'($urandom_range(0, 65535)));
      endcase
      case (p % 4)
        0:       write_reg(CFG_COUNT, 16'(MAX_SRC));
        1:       write_reg(CFG_COUNT, 16'd15);
        2:       write_reg(CFG_COUNT, 16'($urandom_range(2, 7)));
        default: write_reg(CFG_COUNT, 16'($urandom_range(0, 15)));
      endcase
      case (p % 3)
        0:       write_reg(CFG_PENALTY, 16'($urandom_range(1, 12)));
        1:       write_reg(CFG_PENALTY, 16'd255);
        default: write_reg(CFG_PENALTY, 16'($urandom_range(0, 255)));
      endcase
      case (p % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 79; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 79; end
        default: begin in_idle_pct = 15; out_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (p == 5 && n == PHASE_REQS / 2) drain_picks();
        send_request(random_report(), 1'b0, '0);
      end
    end

    drain_picks();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
